// ===== sv/rpim_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpim_pkg
// Shared types and constants of the raster palette index mapper.
// ----------------------------------------------------------------------------
package rpim_pkg;

    localparam logic OP_SCAN = 1'b0;
    localparam logic OP_MAP  = 1'b1;

    localparam int CFG_INDEX_BITS = 4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RANGE_LOW      = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RANGE_HIGH     = 4'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_NODATA_VALUE   = 4'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_NODATA_ENABLE  = 4'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ABSOLUTE_MODE  = 4'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_OVERLAY_ENABLE = 4'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH    = 4'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT   = 4'd7;

    localparam int SIZE_BITS = 13;

    localparam logic [7:0] IDX_NODATA = 8'd0;
    localparam logic [7:0] IDX_MARK   = 8'd1;
    localparam logic [7:0] IDX_BASE   = 8'd2;
    localparam logic [7:0] IDX_EQUAL  = 8'd3;

    localparam logic [31:0] TICK_NEAR = 32'd32;
    localparam logic [31:0] TICK_HALF = 32'd16;

    localparam int QUO_BITS   = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_BITS = 2;

    typedef struct packed {
        logic       div;
        logic [7:0] idx;
        logic       tick;
        logic       row_end;
        logic       frame_end;
    } rpim_tag_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_FIN
    } rpim_back_state_t;

endpackage
`default_nettype wire

// ===== sv/rpim_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpim_front
// Configuration registers, scan fold, pixel counters and classification.
// ----------------------------------------------------------------------------
module rpim_front #(
    parameter int SAMPLE_BITS = 32,
    parameter int COORD_BITS  = 12,
    parameter int CFG_BITS    = 32
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_we,
    input  wire logic [rpim_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire logic [CFG_BITS-1:0]                   cfg_data,
    input  wire logic                                  in_take,
    input  wire logic                                  opcode,
    input  wire logic signed [SAMPLE_BITS-1:0]         sample,
    input  wire logic                                  overlay_mark,
    output      logic                                  push_valid,
    output      rpim_pkg::rpim_tag_t                   push_tag,
    output      logic [SAMPLE_BITS-1:0]                push_num,
    output      logic [SAMPLE_BITS-1:0]                push_den
);
    import rpim_pkg::*;

    localparam int CW = COORD_BITS + 1;
    localparam int EW = (CW > SIZE_BITS) ? CW : SIZE_BITS;
    localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [SAMPLE_BITS-1:0] S_ZERO = '0;
    localparam logic signed [SAMPLE_BITS-1:0] S_ONE = SAMPLE_BITS'(1);
    localparam logic [EW-1:0] SIZE_LIM = EW'(1) << COORD_BITS;

    logic signed [SAMPLE_BITS-1:0] range_low_reg, range_high_reg, nodata_value_reg;
    logic                          nodata_enable_reg, absolute_mode_reg, overlay_enable_reg;
    logic [SIZE_BITS-1:0]          image_width_reg, image_height_reg;

    logic [COORD_BITS-1:0]         col_reg, col_next, row_reg, row_next;
    logic signed [SAMPLE_BITS-1:0] smin_reg, smin_next, smax_reg, smax_next;
    logic                          seen_reg, seen_next;

    logic                          nodata, is_map;
    logic signed [SAMPLE_BITS-1:0] lo, hi;
    logic [EW-1:0]                 wx, hx, we, he;
    logic [CW-1:0]                 w, h, w_m1, h_m1, col_x, row_x, x, y, distx, disty;
    logic [CW-1:0]                 half_w, half_h;
    logic                          rend, fend, tick_hit;
    logic                          div;
    logic [7:0]                    cls_idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_low_reg      <= S_ZERO;
            range_high_reg     <= S_ONE;
            nodata_value_reg   <= S_ZERO;
            nodata_enable_reg  <= 1'b0;
            absolute_mode_reg  <= 1'b0;
            overlay_enable_reg <= 1'b0;
            image_width_reg    <= SIZE_BITS'(1);
            image_height_reg   <= SIZE_BITS'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RANGE_LOW:      range_low_reg      <= cfg_data[SAMPLE_BITS-1:0];
                REG_RANGE_HIGH:     range_high_reg     <= cfg_data[SAMPLE_BITS-1:0];
                REG_NODATA_VALUE:   nodata_value_reg   <= cfg_data[SAMPLE_BITS-1:0];
                REG_NODATA_ENABLE:  nodata_enable_reg  <= cfg_data[0];
                REG_ABSOLUTE_MODE:  absolute_mode_reg  <= cfg_data[0];
                REG_OVERLAY_ENABLE: overlay_enable_reg <= cfg_data[0];
                REG_IMAGE_WIDTH:    image_width_reg    <= cfg_data[SIZE_BITS-1:0];
                REG_IMAGE_HEIGHT:   image_height_reg   <= cfg_data[SIZE_BITS-1:0];
                default:            ;
            endcase
        end
    end

    // effective frame size and position
    always_comb
    begin
        wx = EW'(image_width_reg);
        hx = EW'(image_height_reg);
        we = (wx == '0) ? EW'(1) : ((wx > SIZE_LIM) ? SIZE_LIM : wx);
        he = (hx == '0) ? EW'(1) : ((hx > SIZE_LIM) ? SIZE_LIM : hx);
        w = we[CW-1:0];
        h = he[CW-1:0];
        w_m1 = w - CW'(1);
        h_m1 = h - CW'(1);
        col_x = CW'(col_reg);
        row_x = CW'(row_reg);
        rend = col_x >= w_m1;
        fend = rend && (row_x >= h_m1);
        x = rend ? w_m1 : col_x;
        y = (row_x >= h_m1) ? h_m1 : row_x;
        distx = (x < (w_m1 - x)) ? x : (w_m1 - x);
        disty = (y < (h_m1 - y)) ? y : (h_m1 - y);
        half_w = w >> 1;
        half_h = h >> 1;
        tick_hit = 1'b0;
        if ((distx == '0) && ((32'(disty) < TICK_NEAR) ||
            ((32'(half_h) >= TICK_HALF) && (32'(disty) > 32'(half_h) - TICK_HALF))))
            tick_hit = 1'b1;
        else if ((disty == '0) && ((32'(distx) < TICK_NEAR) ||
            ((32'(half_w) >= TICK_HALF) && (32'(distx) > 32'(half_w) - TICK_HALF))))
            tick_hit = 1'b1;
    end

    // classify
    always_comb
    begin
        nodata = nodata_enable_reg && (sample == nodata_value_reg);
        if (absolute_mode_reg)
        begin
            lo = seen_reg ? smin_reg : S_ZERO;
            hi = seen_reg ? smax_reg : S_ONE;
        end
        else
        begin
            lo = range_low_reg;
            hi = range_high_reg;
        end
        div = 1'b0;
        cls_idx = IDX_MARK;
        if (overlay_enable_reg && overlay_mark)
            cls_idx = IDX_MARK;
        else if (nodata)
            cls_idx = IDX_NODATA;
        else if ((sample < lo) || (sample > hi))
            cls_idx = IDX_MARK;
        else if (lo == hi)
            cls_idx = IDX_EQUAL;
        else
            div = 1'b1;
        push_num = sample - lo;
        push_den = hi - lo;
        push_tag.div = div;
        push_tag.tick = overlay_enable_reg && tick_hit;
        push_tag.idx = (!div && overlay_enable_reg && tick_hit && (cls_idx != IDX_MARK))
                       ? IDX_MARK : cls_idx;
        push_tag.row_end = rend;
        push_tag.frame_end = fend;
        is_map = (opcode == OP_MAP);
        push_valid = in_take && is_map;
    end

    // counters and scan state
    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        smin_next = smin_reg;
        smax_next = smax_reg;
        seen_next = seen_reg;
        if (in_take && is_map)
        begin
            if (fend)
            begin
                col_next  = '0;
                row_next  = '0;
                smin_next = S_MAX;
                smax_next = S_MIN;
                seen_next = 1'b0;
            end
            else if (rend)
            begin
                col_next = '0;
                row_next = row_reg + COORD_BITS'(1);
            end
            else
            begin
                col_next = col_reg + COORD_BITS'(1);
            end
        end
        else if (in_take && !nodata)
        begin
            if (sample < smin_reg)
                smin_next = sample;
            if (sample > smax_reg)
                smax_next = sample;
            seen_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            smin_reg <= S_MAX;
            smax_reg <= S_MIN;
            seen_reg <= 1'b0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            smin_reg <= smin_next;
            smax_reg <= smax_next;
            seen_reg <= seen_next;
        end
    end

endmodule
`default_nettype wire

// ===== sv/rpim_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpim_queue
// Short FIFO of classified pixels between front and back.
// ----------------------------------------------------------------------------
module rpim_queue #(
    parameter int DATA_BITS = 64
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    push,
    input  wire rpim_pkg::rpim_tag_t     push_tag,
    input  wire logic [DATA_BITS-1:0]    push_data,
    output      logic                    full,
    input  wire logic                    pop,
    output      logic                    pop_valid,
    output      rpim_pkg::rpim_tag_t     pop_tag,
    output      logic [DATA_BITS-1:0]    pop_data
);
    import rpim_pkg::*;

    rpim_tag_t                 tag_mem [QUEUE_DEPTH];
    logic [DATA_BITS-1:0]      data_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [QUEUE_PTR_BITS:0]   cnt_reg, cnt_next;
    logic                      do_push, do_pop;

    always_comb
    begin
        full      = (cnt_reg == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
        pop_valid = (cnt_reg != '0);
        pop_tag   = tag_mem[rd_reg];
        pop_data  = data_mem[rd_reg];
        do_push   = push && !full;
        do_pop    = pop && pop_valid;
        wr_next   = do_push ? wr_reg + QUEUE_PTR_BITS'(1) : wr_reg;
        rd_next   = do_pop ? rd_reg + QUEUE_PTR_BITS'(1) : rd_reg;
        cnt_next  = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + (QUEUE_PTR_BITS+1)'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - (QUEUE_PTR_BITS+1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            tag_mem[wr_reg]  <= push_tag;
            data_mem[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule
`default_nettype wire

// ===== sv/rpim_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpim_back
// Scales in-range samples by restoring division and drives the result register.
// ----------------------------------------------------------------------------
module rpim_back #(
    parameter int SAMPLE_BITS = 32
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       q_valid,
    input  wire rpim_pkg::rpim_tag_t        q_tag,
    input  wire logic [2*SAMPLE_BITS-1:0]   q_data,
    output      logic                       q_pop,
    output      logic                       out_valid,
    input  wire logic                       out_ready,
    output      logic [7:0]                 palette_index,
    output      logic                       row_end,
    output      logic                       frame_end
);
    import rpim_pkg::*;

    localparam int NW = SAMPLE_BITS + 10;
    localparam int CNT_BITS = $clog2(QUO_BITS);

    rpim_back_state_t    state_reg, state_next;
    rpim_tag_t           tag_reg, tag_next;
    logic [NW-1:0]       rem_reg, rem_next, dsh_reg, dsh_next;
    logic [QUO_BITS-1:0] quo_reg, quo_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                valid_reg, valid_next;
    logic [7:0]          idx_reg, idx_next;
    logic                rend_reg, rend_next, fend_reg, fend_next;

    logic [SAMPLE_BITS-1:0] num, den;
    logic [NW-1:0]          numx, denx;
    logic                   out_free, ge, load_div, out_load;

    always_comb
    begin
        num = q_data[2*SAMPLE_BITS-1:SAMPLE_BITS];
        den = q_data[SAMPLE_BITS-1:0];
        numx = NW'(num);
        denx = NW'(den);
        out_free = !valid_reg || out_ready;
        ge = (rem_reg >= dsh_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
                if (q_valid && q_tag.div)
                    state_next = BK_DIV;
            BK_DIV:
                if (cnt_reg == '0)
                    state_next = BK_FIN;
            BK_FIN:
                if (out_free)
                    state_next = BK_IDLE;
            default:
                state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop      = 1'b0;
        load_div   = 1'b0;
        out_load   = 1'b0;
        tag_next   = tag_reg;
        rem_next   = rem_reg;
        dsh_next   = dsh_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        rend_next  = rend_reg;
        fend_next  = fend_reg;
        case (state_reg)
            BK_IDLE:
            begin
                load_div = q_valid && q_tag.div;
                out_load = q_valid && !q_tag.div && out_free;
                q_pop    = load_div || out_load;
                if (load_div)
                begin
                    tag_next = q_tag;
                    // 506*num + den over 2*den, quotient is the rounded scale
                    rem_next = (numx << 9) - (numx << 2) - (numx << 1) + denx;
                    dsh_next = denx << (QUO_BITS);
                    quo_next = '0;
                    cnt_next = CNT_BITS'(QUO_BITS - 1);
                end
                if (out_load)
                begin
                    idx_next  = q_tag.idx;
                    rend_next = q_tag.row_end;
                    fend_next = q_tag.frame_end;
                end
            end
            BK_DIV:
            begin
                rem_next = ge ? rem_reg - dsh_reg : rem_reg;
                quo_next = {quo_reg[QUO_BITS-2:0], ge};
                dsh_next = dsh_reg >> 1;
                cnt_next = cnt_reg - CNT_BITS'(1);
            end
            BK_FIN:
            begin
                out_load = out_free;
                if (out_free)
                begin
                    idx_next  = tag_reg.tick ? IDX_MARK : quo_reg + IDX_BASE;
                    rend_next = tag_reg.row_end;
                    fend_next = tag_reg.frame_end;
                end
            end
            default:
                ;
        endcase
        valid_next = out_load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge clk)
    begin
        tag_reg  <= tag_next;
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        quo_reg  <= quo_next;
        idx_reg  <= idx_next;
        rend_reg <= rend_next;
        fend_reg <= fend_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    assign out_valid     = valid_reg;
    assign palette_index = idx_reg;
    assign row_end       = rend_reg;
    assign frame_end     = fend_reg;

endmodule
`default_nettype wire

// ===== sv/raster_palette_index_mapper.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// raster_palette_index_mapper
// Maps raster samples to 8-bit palette indices with scanned or fixed range.
//
//   channel | direction | handshake             | payload
//   cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//   in      | in        | in_valid / in_ready   | opcode, sample, overlay_mark
//   out     | out       | out_valid / out_ready | palette_index, row_end, frame_end
//
// The front takes one item per cycle while the 4-entry queue has room.
// A pixel that needs scaling passes through the back as load, 8 quotient
// steps in the restoring divider, result; any other pixel loads the result.
// Reset loads the register defaults and clears counters and scan range.
// out_ready low holds the result register; the back then stalls, the queue
// fills and in_ready drops. cfg_ready is always high.
// ----------------------------------------------------------------------------
module raster_palette_index_mapper #(
    parameter int SAMPLE_BITS = 32,
    parameter int COORD_BITS  = 12
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_valid,
    output      logic                                 cfg_ready,
    input  wire logic [rpim_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [((SAMPLE_BITS > rpim_pkg::SIZE_BITS) ? SAMPLE_BITS
                        : rpim_pkg::SIZE_BITS)-1:0]   cfg_data,
    input  wire logic                                 in_valid,
    output      logic                                 in_ready,
    input  wire logic                                 opcode,
    input  wire logic signed [SAMPLE_BITS-1:0]        sample,
    input  wire logic                                 overlay_mark,
    output      logic                                 out_valid,
    input  wire logic                                 out_ready,
    output      logic [7:0]                           palette_index,
    output      logic                                 row_end,
    output      logic                                 frame_end
);
    import rpim_pkg::*;

    localparam int CFG_BITS = (SAMPLE_BITS > SIZE_BITS) ? SAMPLE_BITS : SIZE_BITS;

    logic                     in_take, q_push, q_full, q_pop, q_valid;
    rpim_tag_t                push_tag, q_tag;
    logic [SAMPLE_BITS-1:0]   push_num, push_den;
    logic [2*SAMPLE_BITS-1:0] q_data;

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_full;
    assign in_take   = in_valid && in_ready;

    rpim_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COORD_BITS  (COORD_BITS),
        .CFG_BITS    (CFG_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_take      (in_take),
        .opcode       (opcode),
        .sample       (sample),
        .overlay_mark (overlay_mark),
        .push_valid   (q_push),
        .push_tag     (push_tag),
        .push_num     (push_num),
        .push_den     (push_den)
    );

    rpim_queue #(
        .DATA_BITS (2*SAMPLE_BITS)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_tag  (push_tag),
        .push_data ({push_num, push_den}),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_tag   (q_tag),
        .pop_data  (q_data)
    );

    rpim_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_tag         (q_tag),
        .q_data        (q_data),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .palette_index (palette_index),
        .row_end       (row_end),
        .frame_end     (frame_end)
    );

`ifndef ASSERT_OFF
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_full))
        else $error("queue push while full");

    a_scan_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && (opcode == OP_SCAN)) |-> !q_push)
        else $error("scan transfer entered the queue");

    a_map_push: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && (opcode == OP_MAP)) |-> q_push)
        else $error("map transfer not queued");

    a_frame_end_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_end) |-> row_end)
        else $error("frame end without row end");
`endif

endmodule
`default_nettype wire
